/* rtl/core/kctp_pkg.sv */
package kctp_pkg;

  localparam int NAME_W    = 12;
  localparam int NUM_KEYS  = 32;
  localparam int NUM_MODS  = 17;

  localparam int STACK_DEPTH_DEF = 8;
  localparam int TOKEN_CHARS_DEF = 16;
  localparam logic [7:0] MAX_COMBOS_RST = 8'd16;

  localparam logic [7:0] USAGE_A   = 8'h04;
  localparam logic [7:0] USAGE_1   = 8'h1E;
  localparam logic [7:0] USAGE_0   = 8'h27;
  localparam logic [7:0] USAGE_F1  = 8'h3A;
  localparam int         FKEY_MAX  = 12;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  typedef logic [NAME_W*8-1:0] name_t;

  localparam name_t KEY_TXT [NUM_KEYS] = '{
    "return", "enter", "tab", "space", "backspace", "delete", "escape", "esc",
    "insert", "home", "page_up", "end", {"page", "_down"}, "right", "left", "down",
    "up", "minus", "equal", "bracketleft", "bracketright", "backslash",
    "semicolon", "apostrophe", "grave", "comma", "period", "slash",
    "capslock", "print", {"scroll", "_lock"}, "pause"
  };

  localparam logic [7:0] KEY_VAL [NUM_KEYS] = '{
    8'h28, 8'h28, 8'h2B, 8'h2C, 8'h2A, 8'h4C, 8'h29, 8'h29,
    8'h49, 8'h4A, 8'h4B, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51,
    8'h52, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h33, 8'h34,
    8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h46, 8'h47, 8'h48
  };

  localparam name_t MOD_TXT [NUM_MODS] = '{
    "shift", "shift_l", "shift_r", "control", "ctrl", {"control", "_l"},
    {"control", "_r"}, "alt", "alt_l", "alt_r", "option", "super", "super_l",
    "super_r", "meta", "command", "windows"
  };

  localparam logic [7:0] MOD_VAL [NUM_MODS] = '{
    8'h02, 8'h02, 8'h20, 8'h01, 8'h01, 8'h01, 8'h10, 8'h04, 8'h04, 8'h40,
    8'h04, 8'h08, 8'h08, 8'h80, 8'h08, 8'h08, 8'h08
  };

  typedef struct packed {
    logic append;
    logic clear;
  } tok_ctrl_t;

  typedef struct packed {
    logic       open;
    logic [7:0] usage_cur;
    logic [7:0] usage_app;
    logic [7:0] mod_cur;
  } tok_info_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] push_val;
  } stk_ctrl_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // names sit right-justified in the vector, first char in the top used byte
  function automatic logic [7:0] name_char(input name_t txt, input int pos);
    int len;
    logic [7:0] r;
    len = 0;
    r = 8'd0;
    for (int i = 0; i < NAME_W; i++) begin
      if (txt[i*8 +: 8] != 8'd0) begin
        len = i + 1;
      end
    end
    for (int i = 0; i < NAME_W; i++) begin
      if (pos < len && i == len - 1 - pos) begin
        r = txt[i*8 +: 8];
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/key_combo_text_parser_top.sv */
// Parses a key combo string arriving one character per item (last marks the
// final one) and gives one result per character: the HID usage and modifier
// byte when that character completes a known key, plus the running count.
// Names such as "ctrl(" push modifiers onto a small stack, ")" pops them.
// Token matching runs incrementally as each character arrives, so a new item
// is accepted on every clock while the result register is free or being
// drained. max_combos may only be written while no item is in flight.
module key_combo_text_parser_top #(
  parameter int STACK_DEPTH = kctp_pkg::STACK_DEPTH_DEF,
  parameter int TOKEN_CHARS = kctp_pkg::TOKEN_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       max_combos_we,
  input  logic [7:0] max_combos,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       key_valid,
  output logic [7:0] mods,
  output logic [7:0] usage,
  output logic       done_res,
  output logic [7:0] combo_count
);

  logic [7:0] max_reg;
  logic [7:0] emitted;
  logic       acc;
  logic       is_sp, is_tab, is_lp, is_rp, close;
  logic [7:0] key, mask;
  logic       emit;
  logic [7:0] emitted_next;
  kctp_pkg::tok_ctrl_t tctrl;
  kctp_pkg::tok_info_t tinfo;
  kctp_pkg::stk_ctrl_t sctrl;

  kctp_token #(.TOKEN_CHARS(TOKEN_CHARS)) u_token (
    .clk(clk), .rst(rst), .ch(ch), .ctrl(tctrl), .info(tinfo)
  );

  kctp_modstack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .rst(rst), .ctrl(sctrl), .mask(mask)
  );

  assign char_ready = !res_valid || res_ready;
  assign acc = char_valid && char_ready;

  always_comb begin
    is_sp  = (ch == kctp_pkg::CH_SPACE);
    is_tab = (ch == kctp_pkg::CH_TAB);
    is_lp  = (ch == kctp_pkg::CH_LPAR);
    is_rp  = (ch == kctp_pkg::CH_RPAR);
    close  = tinfo.open && (is_sp || is_rp);
    // tabs are only separators outside a token
    tctrl.append = acc && (tinfo.open ? !(is_sp || is_rp || is_lp)
                                      : !(is_sp || is_tab || is_rp || is_lp));
    tctrl.clear  = acc && (close || (tinfo.open && is_lp) || last);
    sctrl.push     = acc && is_lp;
    sctrl.pop      = acc && is_rp;
    sctrl.clear    = acc && last;
    sctrl.push_val = tinfo.open ? tinfo.mod_cur : 8'd0;
    if (close) begin
      key = tinfo.usage_cur;
    end else if (last && tctrl.append) begin
      key = tinfo.usage_app;
    end else begin
      key = 8'd0;
    end
    emit = (key != 8'd0) && (emitted < max_reg);
    emitted_next = emitted + {7'd0, emit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_reg <= kctp_pkg::MAX_COMBOS_RST;
    end else if (max_combos_we) begin
      max_reg <= max_combos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitted <= 8'd0;
      res_valid <= 1'b0;
    end else begin
      if (acc) begin
        emitted <= last ? 8'd0 : emitted_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      key_valid <= emit;
      mods <= emit ? mask : 8'd0;
      usage <= emit ? key : 8'd0;
      done_res <= last;
      combo_count <= emitted_next;
    end
  end

  a_no_key_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !key_valid |-> usage == 8'd0 && mods == 8'd0)
    else $error("payload not zero without key");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && key_valid |-> combo_count != 8'd0)
    else $error("key emitted with zero count");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    acc && last |=> emitted == 8'd0)
    else $error("count not cleared after last item");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(combo_count))
    else $error("result lost under stall");

endmodule

/* rtl/core/kctp_token.sv */
module kctp_token #(
  parameter int TOKEN_CHARS = kctp_pkg::TOKEN_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          ch,
  input  kctp_pkg::tok_ctrl_t ctrl,
  output kctp_pkg::tok_info_t info
);

  localparam int LW = $clog2(TOKEN_CHARS + 1);

  logic [LW-1:0] len;
  logic          ovf;
  logic [7:0]    c0, c1, c2;
  logic [kctp_pkg::NUM_KEYS-1:0] kflags;
  logic [kctp_pkg::NUM_MODS-1:0] mflags;

  logic [LW-1:0] len_next;
  logic          ovf_next;
  logic [7:0]    c0_next, c1_next, c2_next;
  logic [kctp_pkg::NUM_KEYS-1:0] kflags_next;
  logic [kctp_pkg::NUM_MODS-1:0] mflags_next;
  logic [7:0]    ch_lc;

  function automatic logic [7:0] tok_usage(
    input logic [LW-1:0] l, input logic o,
    input logic [7:0] a, input logic [7:0] b, input logic [7:0] d,
    input logic [kctp_pkg::NUM_KEYS-1:0] kf);
    logic [7:0] r;
    logic [7:0] lc;
    logic [6:0] v;
    logic       digits;
    r = 8'd0;
    lc = kctp_pkg::to_lower(a);
    v = 7'd0;
    digits = 1'b0;
    if (!o && l != '0) begin
      for (int k = 0; k < kctp_pkg::NUM_KEYS; k++) begin
        if (kf[k] && kctp_pkg::name_char(kctp_pkg::KEY_TXT[k], int'(l)) == 8'd0) begin
          r = kctp_pkg::KEY_VAL[k];
        end
      end
      if (l == LW'(1)) begin
        if (lc >= "a" && lc <= "z") begin
          r = kctp_pkg::USAGE_A + (lc - "a");
        end else if (lc >= "1" && lc <= "9") begin
          r = kctp_pkg::USAGE_1 + (lc - "1");
        end else if (lc == "0") begin
          r = kctp_pkg::USAGE_0;
        end
      end else if (lc == "f" && (l == LW'(2) || l == LW'(3))) begin
        if (l == LW'(2)) begin
          digits = (b >= "0" && b <= "9");
          v = 7'(b - "0");
        end else begin
          digits = (b >= "0" && b <= "9") && (d >= "0" && d <= "9");
          v = 7'((b - "0") * 8'd10 + (d - "0"));
        end
        r = 8'd0;
        if (digits && v >= 7'd1 && v <= 7'(kctp_pkg::FKEY_MAX)) begin
          r = kctp_pkg::USAGE_F1 + 8'(v) - 8'd1;
        end
      end
    end
    return r;
  endfunction

  // state as it would be after appending ch
  always_comb begin
    ch_lc = kctp_pkg::to_lower(ch);
    len_next = len;
    ovf_next = ovf;
    c0_next = c0;
    c1_next = c1;
    c2_next = c2;
    kflags_next = kflags;
    mflags_next = mflags;
    if (len < LW'(TOKEN_CHARS)) begin
      len_next = len + LW'(1);
      if (len == LW'(0)) c0_next = ch;
      if (len == LW'(1)) c1_next = ch;
      if (len == LW'(2)) c2_next = ch;
      for (int k = 0; k < kctp_pkg::NUM_KEYS; k++) begin
        kflags_next[k] = kflags[k] && ch_lc != 8'd0 &&
          ch_lc == kctp_pkg::name_char(kctp_pkg::KEY_TXT[k], int'(len));
      end
      for (int k = 0; k < kctp_pkg::NUM_MODS; k++) begin
        mflags_next[k] = mflags[k] && ch_lc != 8'd0 &&
          ch_lc == kctp_pkg::name_char(kctp_pkg::MOD_TXT[k], int'(len));
      end
    end else begin
      ovf_next = 1'b1;
    end
  end

  always_comb begin
    info.open = (len != '0) || ovf;
    info.usage_cur = tok_usage(len, ovf, c0, c1, c2, kflags);
    info.usage_app = tok_usage(len_next, ovf_next, c0_next, c1_next, c2_next,
                               kflags_next);
    info.mod_cur = 8'd0;
    if (!ovf) begin
      for (int k = 0; k < kctp_pkg::NUM_MODS; k++) begin
        if (mflags[k] && kctp_pkg::name_char(kctp_pkg::MOD_TXT[k], int'(len)) == 8'd0) begin
          info.mod_cur = kctp_pkg::MOD_VAL[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      len <= '0;
      ovf <= 1'b0;
      kflags <= '1;
      mflags <= '1;
    end else if (ctrl.append) begin
      len <= len_next;
      ovf <= ovf_next;
      kflags <= kflags_next;
      mflags <= mflags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append) begin
      c0 <= c0_next;
      c1 <= c1_next;
      c2 <= c2_next;
    end
  end

endmodule

/* rtl/core/kctp_modstack.sv */
module kctp_modstack #(
  parameter int STACK_DEPTH = kctp_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  kctp_pkg::stk_ctrl_t ctrl,
  output logic [7:0]          mask
);

  localparam int LVW = $clog2(STACK_DEPTH + 1);
  localparam int IW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [7:0]     entry [STACK_DEPTH];
  logic [LVW-1:0] level;
  logic [LVW-1:0] top_idx;

  assign top_idx = level - LVW'(1);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      level <= '0;
      mask <= 8'd0;
    end else if (ctrl.push && level < LVW'(STACK_DEPTH)) begin
      level <= level + LVW'(1);
      mask <= mask | ctrl.push_val;
    end else if (ctrl.pop && level != '0) begin
      level <= top_idx;
      mask <= mask & ~entry[top_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.clear && ctrl.push && level < LVW'(STACK_DEPTH)) begin
      entry[level[IW-1:0]] <= ctrl.push_val;
    end
  end

endmodule

/* bench/key_combo_text_parser_checker.sv */
`timescale 1ns / 1ps
module key_combo_text_parser_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       max_combos_we,
  input  logic [7:0] max_combos,
  input  logic       char_valid,
  input  logic       char_ready,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic       res_valid,
  input  logic       res_ready,
  input  logic       key_valid,
  input  logic [7:0] mods,
  input  logic [7:0] usage,
  input  logic       done_res,
  input  logic [7:0] combo_count,
  output int         fail_count,
  output int         pending,
  output int         keys_seen
);

  typedef struct packed {
    logic       key_valid;
    logic [7:0] mods;
    logic [7:0] usage;
    logic       done_res;
    logic [7:0] combo_count;
  } combo_res_t;

  localparam int STK = kctp_pkg::STACK_DEPTH_DEF;
  localparam int TOKN = kctp_pkg::TOKEN_CHARS_DEF;

  combo_res_t combo_q[$];
  logic [7:0] limit_r;
  logic [7:0] tok [TOKN];
  int         tok_len;
  bit         tok_ovf;
  logic [7:0] stk [STK];
  int         lvl;
  logic [7:0] mask;
  logic [7:0] sent;

  // byte-wise compare, so a zero byte in the token never matches
  function automatic bit tok_is(input string nm);
    if (nm.len() != tok_len) return 1'b0;
    for (int i = 0; i < tok_len; i++)
      if (kctp_pkg::to_lower(tok[i]) != nm[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] key_of_token();
    string knames [32];
    logic [7:0] kvals [32];
    logic [7:0] c;
    int v;
    if (tok_ovf || tok_len == 0) return 8'd0;
    knames = '{"return", "enter", "tab", "space", "backspace", "delete", "escape",
      "esc", "insert", "home", "page_up", "end", {"page", "_down"}, "right", "left",
      "down", "up", "minus", "equal", "bracketleft", "bracketright", "backslash",
      "semicolon", "apostrophe", "grave", "comma", "period", "slash", "capslock",
      "print", {"scroll", "_lock"}, "pause"};
    kvals = '{8'h28, 8'h28, 8'h2B, 8'h2C, 8'h2A, 8'h4C, 8'h29, 8'h29, 8'h49,
      8'h4A, 8'h4B, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h2D, 8'h2E,
      8'h2F, 8'h30, 8'h31, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h46, 8'h47, 8'h48};
    if (tok_len == 1) begin
      c = kctp_pkg::to_lower(tok[0]);
      if (c >= "a" && c <= "z") return 8'h04 + (c - "a");
      if (c >= "1" && c <= "9") return 8'h1E + (c - "1");
      if (c == "0") return 8'h27;
    end
    if ((tok[0] == "f" || tok[0] == "F") && tok_len >= 2 && tok_len <= 3) begin
      v = 0;
      for (int i = 1; i < tok_len; i++) begin
        if (tok[i] < "0" || tok[i] > "9") return 8'd0;
        v = v * 10 + (tok[i] - "0");
      end
      if (v >= 1 && v <= 12) return 8'(8'h3A + v - 1);
    end
    for (int k = 0; k < 32; k++) if (tok_is(knames[k])) return kvals[k];
    return 8'd0;
  endfunction

  function automatic logic [7:0] mod_of_token();
    string mnames [17];
    logic [7:0] mvals [17];
    if (tok_ovf) return 8'd0;
    mnames = '{"shift", "shift_l", "shift_r", "control", "ctrl", {"control", "_l"},
      {"control", "_r"}, "alt", "alt_l", "alt_r", "option", "super", "super_l",
      "super_r", "meta", "command", "windows"};
    mvals = '{8'h02, 8'h02, 8'h20, 8'h01, 8'h01, 8'h01, 8'h10, 8'h04, 8'h04,
      8'h40, 8'h04, 8'h08, 8'h08, 8'h80, 8'h08, 8'h08, 8'h08};
    for (int k = 0; k < 17; k++) if (tok_is(mnames[k])) return mvals[k];
    return 8'd0;
  endfunction

  task automatic push_mod(input logic [7:0] m);
    if (lvl < STK) begin
      stk[lvl] = m;
      lvl++;
      mask |= m;
    end
  endtask

  task automatic pop_mod();
    if (lvl > 0) begin
      lvl--;
      mask &= ~stk[lvl];
    end
  endtask

  task automatic add_char(input logic [7:0] c);
    if (tok_len < TOKN) begin
      tok[tok_len] = c;
      tok_len++;
    end else begin
      tok_ovf = 1;
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic fin);
    combo_res_t r;
    logic [7:0] key;
    bit open;
    key = 0;
    r = '0;
    open = tok_len > 0 || tok_ovf;
    if (!open) begin
      if (c == kctp_pkg::CH_RPAR) pop_mod();
      else if (c == kctp_pkg::CH_LPAR) push_mod(8'd0);
      else if (c != kctp_pkg::CH_SPACE && c != kctp_pkg::CH_TAB) add_char(c);
    end else if (c == kctp_pkg::CH_SPACE || c == kctp_pkg::CH_RPAR) begin
      key = key_of_token();
      tok_len = 0;
      tok_ovf = 0;
      if (c == kctp_pkg::CH_RPAR) begin
        if (key != 0 && sent < limit_r) begin
          r.key_valid = 1;
          r.mods = mask;
          r.usage = key;
          sent++;
        end
        key = 0;
        pop_mod();
      end
    end else if (c == kctp_pkg::CH_LPAR) begin
      push_mod(mod_of_token());
      tok_len = 0;
      tok_ovf = 0;
    end else begin
      add_char(c);
    end
    if (fin && (tok_len > 0 || tok_ovf)) begin
      key = key_of_token();
      tok_len = 0;
      tok_ovf = 0;
    end
    if (key != 0 && !r.key_valid && sent < limit_r) begin
      r.key_valid = 1;
      r.mods = mask;
      r.usage = key;
      sent++;
    end
    r.done_res = fin;
    r.combo_count = sent;
    combo_q.push_back(r);
    if (fin) begin
      tok_len = 0;
      tok_ovf = 0;
      lvl = 0;
      mask = 0;
      sent = 0;
    end
  endtask

  always @(posedge clk) begin
    combo_res_t want, got;
    if (rst) begin
      limit_r <= kctp_pkg::MAX_COMBOS_RST;
      tok_len = 0;
      tok_ovf = 0;
      lvl = 0;
      mask = 0;
      sent = 0;
      fail_count <= 0;
      keys_seen <= 0;
      combo_q.delete();
      pending <= 0;
    end else begin
      if (res_valid && res_ready) begin
        got = '{key_valid, mods, usage, done_res, combo_count};
        if (combo_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = combo_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: exp kv=%b mods=%h usage=%h done=%b cnt=%0d",
                want.key_valid, want.mods, want.usage, want.done_res,
                want.combo_count);
              $display("          got kv=%b mods=%h usage=%h done=%b cnt=%0d",
                got.key_valid, got.mods, got.usage, got.done_res, got.combo_count);
            end
            fail_count <= fail_count + 1;
          end
          if (got.key_valid) keys_seen <= keys_seen + 1;
        end
      end
      if (char_valid && char_ready) parse_char(ch, last);
      if (max_combos_we) limit_r <= max_combos;
      pending <= combo_q.size();
    end
  end
endmodule

/* bench/key_combo_text_parser_top_tb.sv */
`timescale 1ns / 1ps
module key_combo_text_parser_top_tb;
  logic       clk = 0;
  logic       rst = 1;
  logic       max_combos_we = 0;
  logic [7:0] max_combos = 0;
  logic       char_valid = 0;
  logic       char_ready;
  logic [7:0] ch = 0;
  logic       last = 0;
  logic       res_valid;
  logic       res_ready = 0;
  logic       key_valid, done_res;
  logic [7:0] mods, usage, combo_count;
  int fail_count, pending, keys_seen;
  int send_idle = 0, recv_idle = 0;
  int chars_sent = 0, strings_sent = 0;
  longint cycles = 0;

  always #4 clk = ~clk;

  key_combo_text_parser_top u_dut (.*);
  key_combo_text_parser_checker u_chk (.*);

  // receiver stall, re-rolled every cycle
  always @(negedge clk) res_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays up between back-to-back items; idle cycles and drain drop it
  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      char_valid <= 0;
      @(negedge clk);
    end
    char_valid <= 1;
    ch <= c;
    last <= fin;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    chars_sent++;
    if (fin) strings_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    char_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(input logic [7:0] v);
    drain();
    max_combos_we <= 1;
    max_combos <= v;
    @(negedge clk);
    max_combos_we <= 0;
  endtask

  function automatic string rand_token();
    string pool [16];
    string s;
    int n;
    pool = '{"a", "Z", "7", "0", "f1", "F12", "f13", "return", {"Page", "_Down"},
      "escape", "pause", {"scroll", "_lock"}, "x1", "esc", "up", "grave"};
    case ($urandom_range(3))
      0: begin
        s = "";
        n = $urandom_range(1, 19);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(33, 126)))};
        return s;
      end
      default: return pool[$urandom_range(15)];
    endcase
  endfunction

  function automatic string rand_combo();
    string mods_pool [8];
    string s;
    int depth;
    mods_pool = '{"ctrl", "SHIFT", "alt_r", "super_r", {"control", "_r"}, "shift_r",
      "meta", "bogus"};
    s = "";
    depth = $urandom_range(0, 3);
    for (int i = 0; i < $urandom_range(1, 4); i++) begin
      if ($urandom_range(2) == 0) s = {s, " "};
      for (int j = 0; j < depth; j++) s = {s, mods_pool[$urandom_range(7)], "("};
      s = {s, rand_token()};
      for (int j = 0; j < depth; j++) if ($urandom_range(5) != 0) s = {s, ")"};
      s = {s, " "};
    end
    return s;
  endfunction

  task automatic rand_string();
    string s;
    int n;
    if ($urandom_range(9) == 0) begin
      // raw noise, every byte value possible
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) send_char(8'($urandom_range(255)), i == n - 1);
    end else begin
      s = rand_combo();
      if ($urandom_range(1)) s = s.substr(0, s.len() - 2);
      send_text(s);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed strings
    send_text("ctrl(shift(a))");
    send_text("F1 f12 f13 0 9 z Return");
    send_text("((((((((((a))))))))))");
    send_text("super_r(alt_r(control_r(shift_r(x))))");
    send_text("abcdefghijklmnopqrstu ");
    send_text("a\tb \tc");
    send_text(")");
    send_text("bogus(windows(pause)");
    set_limit(8'd0);
    send_text("a b c");
    set_limit(8'd255);
    send_text("a b c d e");
    set_limit(8'd2);
    send_text("x y z");
    send_char(8'hFF, 0);
    send_char(8'h80, 1);
    send_idle = 13;
    recv_idle = 82;
    while (chars_sent < 600) rand_string();
    drain();
    set_limit(8'd1);
    send_idle = 82;
    recv_idle = 13;
    while (chars_sent < 1100) rand_string();
    set_limit(8'd16);
    send_idle = 0;
    recv_idle = 0;
    while (chars_sent < 1450) rand_string();
    drain();
    $display("sent %0d characters in %0d strings, %0d keys emitted", chars_sent,
      strings_sent, keys_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* key_combo_text_parser_top.f */
rtl/core/kctp_pkg.sv
rtl/core/kctp_token.sv
rtl/core/kctp_modstack.sv
rtl/core/key_combo_text_parser_top.sv
bench/key_combo_text_parser_checker.sv
bench/key_combo_text_parser_top_tb.sv
